// ===== rtl/core/sip_pkg.sv =====
// shared constants for the segment intersection point block
// no dependencies; used by sip_back, the top level and sip_checker
package sip_pkg;

  // default coordinate width of one input corner value
  localparam int COORD_BITS_DEF = 16;
  // default fraction bits of the intersection point
  localparam int FRAC_BITS_DEF  = 8;
  // width of one output coordinate field
  localparam int OUT_BITS       = 24;
  // entries in the queue between classifier and divider
  localparam int QUEUE_DEPTH    = 4;

endpackage

// ===== rtl/core/sip_front.sv =====
// front part: edge differences, determinant and parameter numerators, hit test,
// and the point dividends; does not use sip_pkg
module sip_front #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8,
  parameter int NW         = 2 * (COORD_BITS + 1) + 1,
  parameter int SW         = NW + COORD_BITS + 2 + FRAC_BITS,
  parameter int PLW        = 3 + NW + 2 * SW
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [8*COORD_BITS-1:0] in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PLW-1:0]          out_data
);

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int PW = 2 * DW;
  localparam int MW = NW + DW;

  logic       fen;
  logic [7:1] v;

  logic signed [C-1:0] ax, ay, bx, by, cx, cy, dx, dy;

  logic signed [DW-1:0] e0, e1, e2, e3, e4, e5, e6, e7;
  logic signed [C-1:0]  ax1, ay1;
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [C-1:0]  ax2, ay2;
  logic signed [DW-1:0] dlx2, dly2;
  logic signed [NW-1:0] den3, ns3, nt3;
  logic signed [C-1:0]  ax3, ay3;
  logic signed [DW-1:0] dlx3, dly3;
  logic signed [NW-1:0] den4, ns4, nt4;
  logic signed [C-1:0]  ax4, ay4;
  logic signed [DW-1:0] dlx4, dly4;
  logic                 hit5;
  logic signed [NW-1:0] den5;
  logic signed [MW-1:0] mx5, nx5, my5, ny5;
  logic                 hit6;
  logic signed [NW-1:0] den6;
  logic signed [SW-1:0] sx6, sy6;
  logic                 hit7, negx7, negy7;
  logic [NW-1:0]        den7;
  logic [SW-1:0]        magx7, magy7;

  // corner unpacking
  assign ax = $signed(in_data[0*C +: C]);
  assign ay = $signed(in_data[1*C +: C]);
  assign bx = $signed(in_data[2*C +: C]);
  assign by = $signed(in_data[3*C +: C]);
  assign cx = $signed(in_data[4*C +: C]);
  assign cy = $signed(in_data[5*C +: C]);
  assign dx = $signed(in_data[6*C +: C]);
  assign dy = $signed(in_data[7*C +: C]);

  // whole front advances together, held while the queue is full and the last stage holds a request
  assign fen       = !v[7] || out_ready;
  assign in_ready  = fen;
  assign out_valid = v[7];
  assign out_data  = {hit7, negy7, negx7, den7, magy7, magx7};

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (fen) begin
      v <= {v[6:1], in_valid};
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (fen) begin
      // edge differences
      e0  <= DW'(dx) - DW'(cx);
      e1  <= DW'(by) - DW'(ay);
      e2  <= DW'(bx) - DW'(ax);
      e3  <= DW'(dy) - DW'(cy);
      e4  <= DW'(ax) - DW'(cx);
      e5  <= DW'(ay) - DW'(cy);
      e6  <= DW'(cy) - DW'(by);
      e7  <= DW'(bx) - DW'(cx);
      ax1 <= ax;
      ay1 <= ay;
      // cross products
      p0   <= PW'(e0) * PW'(e1);
      p1   <= PW'(e2) * PW'(e3);
      p2   <= PW'(e4) * PW'(e3);
      p3   <= PW'(e0) * PW'(e5);
      p4   <= PW'(e4) * PW'(e6);
      p5   <= PW'(e7) * PW'(e5);
      ax2  <= ax1;
      ay2  <= ay1;
      dlx2 <= e2;
      dly2 <= e1;
      // determinant and numerators
      den3 <= NW'(p0) - NW'(p1);
      ns3  <= NW'(p2) - NW'(p3);
      nt3  <= -NW'(p4) - NW'(p5);
      ax3  <= ax2;
      ay3  <= ay2;
      dlx3 <= dlx2;
      dly3 <= dly2;
      // make the determinant positive
      den4 <= den3[NW-1] ? -den3 : den3;
      ns4  <= den3[NW-1] ? -ns3 : ns3;
      nt4  <= den3[NW-1] ? -nt3 : nt3;
      ax4  <= ax3;
      ay4  <= ay3;
      dlx4 <= dlx3;
      dly4 <= dly3;
      // range test and point products
      hit5 <= (den4 != '0) && !ns4[NW-1] && (ns4 <= den4) && !nt4[NW-1] && (nt4 <= den4);
      den5 <= den4;
      mx5  <= MW'(ax4) * MW'(den4);
      nx5  <= MW'(ns4) * MW'(dlx4);
      my5  <= MW'(ay4) * MW'(den4);
      ny5  <= MW'(ns4) * MW'(dly4);
      // scaled dividends
      hit6 <= hit5;
      den6 <= den5;
      sx6  <= (SW'(mx5) + SW'(nx5)) <<< FRAC_BITS;
      sy6  <= (SW'(my5) + SW'(ny5)) <<< FRAC_BITS;
      // sign and magnitude
      hit7  <= hit6;
      den7  <= den6;
      negx7 <= sx6[SW-1];
      negy7 <= sy6[SW-1];
      magx7 <= sx6[SW-1] ? -sx6 : sx6;
      magy7 <= sy6[SW-1] ? -sy6 : sy6;
    end
  end

endmodule

// ===== rtl/core/sip_queue.sv =====
// small queue between the classifier and the divider pipeline
// register array with head read; the top sets its depth from sip_pkg
module sip_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr, rptr;
  logic [CW-1:0]    count;
  logic             push, pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_data;
    end
  end

endmodule

// ===== rtl/core/sip_back.sv =====
// back part: restoring division pipeline, one quotient bit per stage per axis,
// then sign, miss value and the output register; uses sip_pkg
module sip_back #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8,
  parameter int NW         = 2 * (COORD_BITS + 1) + 1,
  parameter int SW         = NW + COORD_BITS + 2 + FRAC_BITS,
  parameter int PLW        = 3 + NW + 2 * SW
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [PLW-1:0]               in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2*sip_pkg::OUT_BITS-1:0] out_data,
  output logic                         out_hit
);

  localparam int QW = COORD_BITS + FRAC_BITS;
  localparam int OW = sip_pkg::OUT_BITS;
  localparam logic [OW-1:0] MISS = '0 - (OW'(1) << FRAC_BITS);

  logic ben;

  logic [QW-1:0] bv;
  logic [QW-1:0] bhit, bnegx, bnegy;
  logic [NW-1:0] bden [QW];
  logic [NW-1:0] remx [QW];
  logic [NW-1:0] remy [QW];
  logic [QW-1:0] lox  [QW];
  logic [QW-1:0] loy  [QW];

  logic [NW-1:0] in_den;
  logic [SW-1:0] in_magx, in_magy;

  logic signed [QW:0] qx, qy;

  assign in_magx = in_data[0 +: SW];
  assign in_magy = in_data[SW +: SW];
  assign in_den  = in_data[2*SW +: NW];

  // whole back advances together, held while the output waits
  assign ben      = !out_valid || out_ready;
  assign in_ready = ben;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      bv        <= '0;
      out_valid <= 1'b0;
    end else if (ben) begin
      bv        <= {bv[QW-2:0], in_valid};
      out_valid <= bv[QW-1];
    end
  end

  // division stages
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [NW-1:0] rx_in, ry_in, den_in, tx, ty;
    logic [QW-1:0] lx_in, ly_in;
    logic          gx, gy;
    logic          h_in, ngx_in, ngy_in;

    if (k == 0) begin : g_first
      assign rx_in  = in_magx[QW +: NW];
      assign ry_in  = in_magy[QW +: NW];
      assign lx_in  = in_magx[QW-1:0];
      assign ly_in  = in_magy[QW-1:0];
      assign den_in = in_den;
      assign h_in   = in_data[PLW-1];
      assign ngy_in = in_data[PLW-2];
      assign ngx_in = in_data[PLW-3];
    end else begin : g_next
      assign rx_in  = remx[k-1];
      assign ry_in  = remy[k-1];
      assign lx_in  = lox[k-1];
      assign ly_in  = loy[k-1];
      assign den_in = bden[k-1];
      assign h_in   = bhit[k-1];
      assign ngy_in = bnegy[k-1];
      assign ngx_in = bnegx[k-1];
    end

    // trial subtract of the shifted remainder
    assign tx = {rx_in[NW-2:0], lx_in[QW-1]};
    assign ty = {ry_in[NW-2:0], ly_in[QW-1]};
    assign gx = (tx >= den_in);
    assign gy = (ty >= den_in);

    always_ff @(posedge clk) begin
      if (ben) begin
        remx[k]  <= gx ? tx - den_in : tx;
        remy[k]  <= gy ? ty - den_in : ty;
        lox[k]   <= {lx_in[QW-2:0], gx};
        loy[k]   <= {ly_in[QW-2:0], gy};
        bden[k]  <= den_in;
        bhit[k]  <= h_in;
        bnegy[k] <= ngy_in;
        bnegx[k] <= ngx_in;
      end
    end
  end

  // apply sign, wrap to field width, substitute the miss value
  assign qx = bnegx[QW-1] ? -$signed({1'b0, lox[QW-1]}) : $signed({1'b0, lox[QW-1]});
  assign qy = bnegy[QW-1] ? -$signed({1'b0, loy[QW-1]}) : $signed({1'b0, loy[QW-1]});

  always_ff @(posedge clk) begin
    if (ben) begin
      out_hit  <= bhit[QW-1];
      out_data <= bhit[QW-1] ? {OW'(qy), OW'(qx)} : {MISS, MISS};
    end
  end

endmodule

// ===== rtl/core/segment_intersection_point_top.sv =====
// top level of the segment intersection point block
// uses sip_pkg, sip_front, sip_queue, sip_back
//
// usage:
//   s_* carries one request per segment pair: eight signed corner values in
//   s_tdata, seg1 start x/y, seg1 end x/y, seg2 start x/y, seg2 end x/y.
//   m_* returns one result per pair: m_tuser is the hit flag, m_tdata holds
//   cross_x and cross_y, signed with FRAC_BITS fraction bits, truncated toward
//   zero; with no hit or parallel segments both are -1.0.
// throughput: one pair per cycle while m_tready stays high; the divider is a pipeline of
//   COORD_BITS+FRAC_BITS restoring stages, one quotient bit each.
// path: a request passes the 7 classifier stages, the queue, the division
//   stages and the output register on its way to the result.
// reset: rst empties the pipelines and the queue; s_tready is high the
//   cycle after.
// stall: when m_tready is low with a result waiting the divider pipeline
//   holds; the classifier keeps filling the queue and drops s_tready only
//   when the queue is full and its last stage holds a request.
module segment_intersection_point_top #(
  parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sip_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
  // seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y
  input  logic [8*COORD_BITS-1:0]        s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // cross_x, cross_y
  output logic [2*sip_pkg::OUT_BITS-1:0] m_tdata,
  // hit
  output logic [0:0]                     m_tuser
);

  localparam int NW  = 2 * (COORD_BITS + 1) + 1;
  localparam int SW  = NW + COORD_BITS + 2 + FRAC_BITS;
  localparam int PLW = 3 + NW + 2 * SW;

  logic           f_valid, f_ready, b_valid, b_ready;
  logic [PLW-1:0] f_data, b_data;

  sip_front #(
    .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .NW(NW), .SW(SW), .PLW(PLW)
  ) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
    .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
  );

  sip_queue #(.WIDTH(PLW), .DEPTH(sip_pkg::QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
  );

  sip_back #(
    .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .NW(NW), .SW(SW), .PLW(PLW)
  ) u_back (
    .clk(clk), .rst(rst),
    .in_valid(b_valid), .in_ready(b_ready), .in_data(b_data),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata),
    .out_hit(m_tuser[0])
  );

endmodule

// ===== rtl/core/sip_checker.sv =====
// port-level checks for the segment intersection point block, bound to the top
// uses sip_pkg
module sip_checker #(
  parameter int FRAC_BITS = sip_pkg::FRAC_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [2*sip_pkg::OUT_BITS-1:0] m_tdata,
  input logic [0:0]                     m_tuser
);

  localparam int OW = sip_pkg::OUT_BITS;
  localparam logic [OW-1:0] MISS = '0 - (OW'(1) << FRAC_BITS);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a miss always reports -1.0 on both axes
  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[OW-1:0] == MISS && m_tdata[2*OW-1:OW] == MISS)
    else $error("miss without -1.0 point");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // ready to take requests right after reset
  a_rdy: assert property (@(posedge clk) rst |=> s_tready)
    else $error("not ready after reset");

endmodule

bind segment_intersection_point_top sip_checker #(.FRAC_BITS(FRAC_BITS)) u_sip_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

// ===== test/segment_intersection_point_checker.sv =====
// checker for the segment intersection point block: predicts each result
// from the accepted requests and compares them; depends on sip_pkg
`timescale 1ns / 100ps

module segment_intersection_point_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [127:0]                   s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [2*sip_pkg::OUT_BITS-1:0] m_tdata,
  input  logic [0:0]                     m_tuser,
  output int                             fail_count,
  output int                             pending
);

  localparam int FRAC = sip_pkg::FRAC_BITS_DEF;
  localparam int OW   = sip_pkg::OUT_BITS;

  typedef struct packed {
    logic          hit;
    logic [OW-1:0] cross_y;
    logic [OW-1:0] cross_x;
  } crossing_t;

  crossing_t crossings_due[$];

  // coordinate of the crossing point, truncated toward zero
  function automatic logic [OW-1:0] point_on_seg(longint start, longint delta,
                                                 longint ns, longint den);
    logic signed [127:0] sum;
    logic signed [127:0] q;
    begin
      sum = (128'(signed'(start)) <<< FRAC) * den + 128'(signed'(ns)) * (delta <<< FRAC);
      q = sum / 128'(signed'(den));
      return q[OW-1:0];
    end
  endfunction

  function automatic crossing_t predict_crossing(logic [127:0] d);
    longint ax, ay, bx, by, cx, cy, dx, dy, den, ns, nt;
    crossing_t r;
    begin
      ax = longint'($signed(d[15:0]));    ay = longint'($signed(d[31:16]));
      bx = longint'($signed(d[47:32]));   by = longint'($signed(d[63:48]));
      cx = longint'($signed(d[79:64]));   cy = longint'($signed(d[95:80]));
      dx = longint'($signed(d[111:96]));  dy = longint'($signed(d[127:112]));
      den = ax * (dy - cy) + bx * (cy - dy) + dx * (by - ay) + cx * (ay - by);
      ns = ax * (dy - cy) + cx * (ay - dy) + dx * (cy - ay);
      nt = -(ax * (cy - by) + bx * (ay - cy) + cx * (by - ay));
      if (den < 0) begin
        den = -den; ns = -ns; nt = -nt;
      end
      if (den != 0 && ns >= 0 && ns <= den && nt >= 0 && nt <= den) begin
        r.hit = 1'b1;
        r.cross_x = point_on_seg(ax, bx - ax, ns, den);
        r.cross_y = point_on_seg(ay, by - ay, ns, den);
      end else begin
        r.hit = 1'b0;
        r.cross_x = -(OW'(1) << FRAC);
        r.cross_y = -(OW'(1) << FRAC);
      end
      return r;
    end
  endfunction

  initial pending = 0;

  // watch both channels
  always @(posedge clk) begin
    crossing_t want;
    if (rst) begin
      crossings_due.delete();
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready) crossings_due.push_back(predict_crossing(s_tdata));
      if (m_tvalid && m_tready) begin
        if (crossings_due.size() == 0) begin
          $display("%0t: result with no request waiting: hit %0b data %h",
                   $time, m_tuser, m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = crossings_due.pop_front();
          if (want.hit !== m_tuser[0] || want.cross_x !== m_tdata[OW-1:0] ||
              want.cross_y !== m_tdata[2*OW-1:OW]) begin
            $display("%0t: expected hit %0b x %h y %h, got hit %0b x %h y %h", $time,
                     want.hit, want.cross_x, want.cross_y,
                     m_tuser[0], m_tdata[OW-1:0], m_tdata[2*OW-1:OW]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = crossings_due.size();
  end

endmodule

// ===== test/segment_intersection_point_top_test.sv =====
// stimulus and verdict for the segment intersection point block
// depends on segment_intersection_point_top and the checker module
`timescale 1ns / 100ps

module segment_intersection_point_top_test;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [47:0]  m_tdata;
  logic [0:0]   m_tuser;
  int           fail_count;
  int           pending;
  bit           hold_off;
  bit           stim_done;

  segment_intersection_point_top uut (.*);

  segment_intersection_point_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, sometimes long
  function automatic int pick_gap();
    int r;
    begin
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
    end
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 40)) - 20);
      3: return 16'($urandom_range(0, 400)) - 16'd200;
      default: return 16'($urandom);
    endcase
  endfunction

  // random pair, often crossing: second segment spans the first
  function automatic logic [127:0] pick_pair();
    logic [127:0] d;
    begin
      for (int i = 0; i < 8; i++) d[16*i +: 16] = pick_coord();
      if ($urandom_range(0, 1)) begin
        d[79:64]   = d[15:0] + d[47:32] - d[31:16];
        d[111:96]  = d[47:32] + d[15:0] - d[63:48];
        d[95:80]   = d[31:16] + d[63:48] - d[47:32] - d[15:0];
        d[127:112] = 16'($urandom_range(0, 200)) - 16'd100;
      end
      return d;
    end
  endfunction

  function automatic logic [127:0] pack8(int a, int b, int c, int e,
                                         int f, int g, int h, int k);
    return {16'(k), 16'(h), 16'(g), 16'(f), 16'(e), 16'(c), 16'(b), 16'(a)};
  endfunction

  // offer one request; valid stays high into the next one when there is no gap
  task automatic send_request(logic [127:0] d);
    int gap;
    begin
      gap = pick_gap();
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= d;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
  endtask

  // stop offering and wait until every result is back
  task automatic drain_results();
    begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
    end
  endtask

  // receiver with random stalls and two long hold-offs
  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    stim_done = 1'b0;
    hold_off = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: crossing, touching ends, parallel, degenerate, extremes
    send_request(pack8(0, 0, 10, 10, 0, 10, 10, 0));
    send_request(pack8(0, 0, 4, 0, 4, 0, 4, 7));
    send_request(pack8(0, 0, 10, 0, 0, 1, 10, 1));
    send_request(pack8(0, 0, 10, 10, 20, 20, 30, 30));
    send_request(pack8(5, 5, 5, 5, 0, 0, 9, 9));
    send_request(pack8(0, 0, 1, 3, 0, 1, 1, 0));
    send_request(pack8(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_request(pack8(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    send_request(pack8(0, 0, 3, 3, 5, 0, 9, 1));
    send_request(pack8(-3, 7, 2, -5, -8, -1, 6, 1));
    send_request(pack8(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    send_request(pack8(-1, -1, -1, -1, -1, -1, -1, -1));
    send_request(128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff);
    send_request(128'h0);
    // sender pauses until every result is back
    drain_results();
    hold_off = 1'b1;
    for (int n = 0; n < 400; n++) begin
      if (n == 200) drain_results();
      send_request(pick_pair());
      if (n == 120) hold_off = 1'b1;
    end
    drain_results();
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
